FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the frame deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Antecedent holds, consequent holds in the same cycle.
`define FDX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdx assertion failed");

// Antecedent holds, consequent holds in the next cycle.
`define FDX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdx assertion failed");

`else

`define FDX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FDX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/fdx_pkg.sv
// ----------------------------------------------------------------------------
// fdx_pkg
// Shared constants and types of the UART frame deframer.
// ----------------------------------------------------------------------------
package fdx_pkg;

  // Default largest payload length and default queue depth
  localparam int MAX_PAYLOAD_DEF = 2;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths fixed by the frame format
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 2;
  localparam int CFG_IDX_W = 8;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd127;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd126;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE = 8'd0,
    CFG_END_BYTE   = 8'd1
  } cfg_reg_e;

  // Parsed frame waiting for the checksum check
  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] payload_first;
    logic [BYTE_W-1:0] payload_second;
    logic [BYTE_W-1:0] xor_sum;
    logic [BYTE_W-1:0] check;
    logic              end_ok;
  } cand_t;

  // Front to queue
  typedef struct packed {
    logic  push;
    cand_t cand;
  } cand_push_t;

  // Queue to back
  typedef struct packed {
    logic  valid;
    cand_t cand;
  } cand_head_t;

endpackage

FILE: hdl/fdx_ifs.sv
// ----------------------------------------------------------------------------
// fdx_ifs
// Handshake channels of the frame deframer: received bytes, configuration
// writes and decoded frames.
// ----------------------------------------------------------------------------
interface fdx_rx_if;
  logic                      valid;
  logic                      ready;
  logic [fdx_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fdx_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fdx_pkg::CFG_IDX_W-1:0] index;
  logic [fdx_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface fdx_frame_if;
  logic                       valid;
  logic                       ready;
  logic [fdx_pkg::BYTE_W-1:0] frame_command;
  logic [fdx_pkg::LEN_W-1:0]  frame_length;
  logic [fdx_pkg::BYTE_W-1:0] payload_first;
  logic [fdx_pkg::BYTE_W-1:0] payload_second;

  modport source (output valid, output frame_command, output frame_length,
                  output payload_first, output payload_second, input ready);
  modport sink (input valid, input frame_command, input frame_length,
                input payload_first, input payload_second, output ready);
endinterface

FILE: hdl/fdx_front.sv
// ----------------------------------------------------------------------------
// fdx_front
// Byte parser: holds the start and end byte registers, tracks the frame
// phase, accumulates the XOR checksum and pushes each completed frame.
// ----------------------------------------------------------------------------
module fdx_front #(
  parameter int MaxPayload = fdx_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fdx_rx_if.sink              rx_i,
  fdx_cfg_if.sink             cfg_i,
  output fdx_pkg::cand_push_t push_o,
  input  logic                q_full_i
);

  localparam int LenW = $clog2(MaxPayload + 1);
  localparam int CntW = $clog2(MaxPayload + 3);
  localparam int LenOutW = fdx_pkg::LEN_W;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_BODY,
    PH_END
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [fdx_pkg::BYTE_W-1:0] start_q, start_d;
  logic [fdx_pkg::BYTE_W-1:0] end_q, end_d;
  logic [fdx_pkg::BYTE_W-1:0] cmd_q, cmd_d;
  logic [LenW-1:0]            len_q, len_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [fdx_pkg::BYTE_W-1:0] xor_q, xor_d;
  logic [fdx_pkg::BYTE_W-1:0] p0_q, p0_d;
  logic [fdx_pkg::BYTE_W-1:0] p1_q, p1_d;
  logic [fdx_pkg::BYTE_W-1:0] chk_q, chk_d;

  logic                       rx_fire;
  logic                       cfg_fire;
  logic                       push_now;
  logic [fdx_pkg::BYTE_W-1:0] b;
  logic [CntW-1:0]            len_ext;

  assign rx_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign rx_fire     = rx_i.valid && rx_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign b           = rx_i.rx_byte;
  assign len_ext     = CntW'(len_q);

  // Decode configuration writes; unknown indexes are ignored
  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (cfg_fire) begin
      unique case (cfg_i.index)
        fdx_pkg::CFG_START_BYTE: start_d = cfg_i.data;
        fdx_pkg::CFG_END_BYTE:   end_d   = cfg_i.data;
        default: ;
      endcase
    end
  end

  // Advance the frame phase on each accepted word
  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    p0_d     = p0_q;
    p1_d     = p1_q;
    chk_d    = chk_q;
    push_now = 1'b0;
    if (rx_fire) begin
      if (b == start_q) begin
        phase_d = PH_CMD;
      end else begin
        unique case (phase_q)
          PH_CMD: begin
            cmd_d   = b;
            xor_d   = b;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (b > fdx_pkg::BYTE_W'(MaxPayload)) begin
              phase_d = PH_HUNT;
            end else begin
              len_d   = LenW'(b);
              xor_d   = xor_q ^ b;
              cnt_d   = '0;
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            if (cnt_q == '0) p0_d = b;
            if (cnt_q == CntW'(1)) p1_d = b;
            if (cnt_q == len_ext) chk_d = b;
            if (cnt_q < len_ext) xor_d = xor_q ^ b;
            cnt_d = cnt_q + CntW'(1);
            if (cnt_q == len_ext + CntW'(1)) phase_d = PH_END;
          end
          PH_END: begin
            push_now = 1'b1;
            phase_d  = PH_HUNT;
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end
  end

  // Build the frame word for the checker
  always_comb begin
    push_o.push                = push_now;
    push_o.cand.command        = cmd_q;
    push_o.cand.length         = LenOutW'(len_q);
    push_o.cand.payload_first  = (len_q != '0) ? p0_q : '0;
    push_o.cand.payload_second = (len_q > LenW'(1)) ? p1_q : '0;
    push_o.cand.xor_sum        = xor_q;
    push_o.cand.check          = chk_q;
    push_o.cand.end_ok         = (b == end_q);
  end

  // Hold phase, registers and frame fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      start_q <= fdx_pkg::START_BYTE_RST;
      end_q   <= fdx_pkg::END_BYTE_RST;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      start_q <= start_d;
      end_q   <= end_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

  // Payload and checksum bytes need no reset
  always_ff @(posedge clk_i) begin
    p0_q  <= p0_d;
    p1_q  <= p1_d;
    chk_q <= chk_d;
  end

endmodule

FILE: hdl/fdx_queue.sv
// ----------------------------------------------------------------------------
// fdx_queue
// Short FIFO of parsed frames between the parser and the checker.
// ----------------------------------------------------------------------------
module fdx_queue #(
  parameter int Depth = fdx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdx_pkg::cand_push_t push_i,
  input  logic                pop_i,
  output fdx_pkg::cand_head_t head_o,
  output logic                full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fdx_pkg::cand_t  slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cand  = slot_q[rd_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Advance pointers and fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop) rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_i.cand;
  end

endmodule

FILE: hdl/fdx_back.sv
// ----------------------------------------------------------------------------
// fdx_back
// Checker: compares the running XOR with the checksum byte, checks the end
// byte, drops bad frames and holds good ones in the output register.
// ----------------------------------------------------------------------------
module fdx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdx_pkg::cand_head_t head_i,
  output logic                pop_o,
  fdx_frame_if.source         frame_o
);

  logic                       valid_q, valid_d;
  logic [fdx_pkg::BYTE_W-1:0] cmd_q;
  logic [fdx_pkg::LEN_W-1:0]  len_q;
  logic [fdx_pkg::BYTE_W-1:0] p0_q;
  logic [fdx_pkg::BYTE_W-1:0] p1_q;
  logic                       good;
  logic                       load;

  assign good  = head_i.cand.end_ok && (head_i.cand.xor_sum == head_i.cand.check);
  assign pop_o = head_i.valid && (!valid_q || frame_o.ready);
  assign load  = pop_o && good;

  // Keep the output word until taken
  always_comb begin
    valid_d = valid_q;
    if (load) valid_d = 1'b1;
    else if (frame_o.ready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= head_i.cand.command;
      len_q <= head_i.cand.length;
      p0_q  <= head_i.cand.payload_first;
      p1_q  <= head_i.cand.payload_second;
    end
  end

  assign frame_o.valid          = valid_q;
  assign frame_o.frame_command  = cmd_q;
  assign frame_o.frame_length   = len_q;
  assign frame_o.payload_first  = p0_q;
  assign frame_o.payload_second = p1_q;

endmodule

FILE: hdl/uart_frame_deframer_xor.sv
// ----------------------------------------------------------------------------
// uart_frame_deframer_xor
// Receives bytes, parses start/command/length/payload/checksum/pad/end
// frames and emits each frame whose XOR checksum and end byte match.
// ----------------------------------------------------------------------------
//  port     dir   word
//  rx_i     in    one received byte
//  cfg_i    in    register write (0: start byte, 1: end byte)
//  frame_o  out   command, length and two payload bytes
//
//  One byte is taken each cycle unless the frame queue is full; the parser
//  keeps a running XOR. A frame result passes the queue, then the output
//  register, after its end byte. rx_i.ready drops only while the frame
//  queue is full, which needs frame_o stalled across several frames. Reset
//  restores start byte 127, end byte 126 and start hunting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_frame_deframer_xor #(
  parameter int MaxPayload = fdx_pkg::MAX_PAYLOAD_DEF,
  parameter int QueueDepth = fdx_pkg::QUEUE_DEPTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  fdx_rx_if.sink      rx_i,
  fdx_cfg_if.sink     cfg_i,
  fdx_frame_if.source frame_o
);

  fdx_pkg::cand_push_t push;
  fdx_pkg::cand_head_t head;
  logic                q_full;
  logic                pop;

  fdx_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .cfg_i   (cfg_i),
    .push_o  (push),
    .q_full_i(q_full)
  );

  fdx_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .full_o(q_full)
  );

  fdx_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .frame_o(frame_o)
  );

  // A frame is pushed only on an accepted word and never into a full queue
  `FDX_ASSERT_IMPL(a_push_on_accept, clk_i, rst_ni, push.push, rx_i.valid && rx_i.ready && !q_full)
  // The checker pops only a filled slot
  `FDX_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, head.valid)
  // A fresh result always comes from a popped frame
  `FDX_ASSERT_IMPL(a_out_from_queue, clk_i, rst_ni, $rose(frame_o.valid), $past(pop))

endmodule

FILE: test/uart_frame_deframer_xor_test.sv
// ----------------------------------------------------------------------------
// uart_frame_deframer_xor_test
// Self-checking bench for the byte-serial frame deframer. A short directed
// table walks the frame extremes, the oversize drop and a restart inside the
// payload. Random frames follow, most well formed and the rest corrupted or
// noise, under several start/end byte settings. Every decoded frame is checked
// against a typed-in frame or a local parser while both channels idle at random.
// ----------------------------------------------------------------------------
module uart_frame_deframer_xor_test;

  localparam int BYTE_W        = fdx_pkg::BYTE_W;
  localparam int LEN_W         = fdx_pkg::LEN_W;
  localparam int CFG_IDX_W     = fdx_pkg::CFG_IDX_W;
  localparam int MAX_LEN       = fdx_pkg::MAX_PAYLOAD_DEF;
  localparam int BODY_DEPTH    = MAX_LEN + 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 1000;
  localparam int N_SETTINGS    = 6;
  localparam int SETTING_BYTES = 270;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } frame_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    frame_t            frame;
  } dir_row_t;

  typedef enum logic [2:0] {
    HUNT, GET_CMD, GET_LEN, GET_BODY, GET_END
  } parse_e;

  localparam frame_t NO_FRAME = '0;

  // Directed rows run under the reset values: start 7F, end 7E
  localparam dir_row_t DIRECTED [27] = '{
    // shortest frame, all zero
    '{8'h7F, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
    '{8'h7E, 1'b1, '{8'h00, 2'd0, 8'h00, 8'h00}},
    // longest frame with extreme bytes
    '{8'h7F, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'h02, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h02, 1'b0, NO_FRAME},
    '{8'h80, 1'b0, NO_FRAME},
    '{8'h7E, 1'b1, '{8'hFF, 2'd2, 8'hFF, 8'h00}},
    // oversize length drops the frame, then a stray byte while hunting
    '{8'h7F, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME}, '{8'h03, 1'b0, NO_FRAME},
    '{8'h7E, 1'b0, NO_FRAME},
    // start byte inside the payload restarts the frame
    '{8'h7F, 1'b0, NO_FRAME}, '{8'h10, 1'b0, NO_FRAME}, '{8'h01, 1'b0, NO_FRAME},
    '{8'h7F, 1'b0, NO_FRAME}, '{8'h20, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h20, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h7E, 1'b0, NO_FRAME}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fdx_rx_if    rx_bus ();
  fdx_cfg_if   cfg_bus ();
  fdx_frame_if frame_bus ();

  uart_frame_deframer_xor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_bus),
    .cfg_i   (cfg_bus),
    .frame_o (frame_bus)
  );

  always #2 clk_i = ~clk_i;

  // Sideband travelling with each word: a typed-in expected frame
  logic   typed_on;
  frame_t typed_frame;

  // Frame parser state and register copies
  parse_e            pr_phase;
  logic [BYTE_W-1:0] pr_cmd;
  logic [LEN_W-1:0]  pr_len;
  int                pr_count;
  logic [BYTE_W-1:0] pr_body [BODY_DEPTH];
  logic [BYTE_W-1:0] pr_xor;
  logic [BYTE_W-1:0] cur_start;
  logic [BYTE_W-1:0] cur_end;

  frame_t      frames_due [$];
  int unsigned fail_count;
  int unsigned bytes_seen;
  int unsigned frames_seen;
  int unsigned idle_cycles;

  // Stimulus side
  logic [BYTE_W-1:0] ph_start;
  logic [BYTE_W-1:0] ph_end;
  logic [BYTE_W-1:0] tx_q [$];
  int                setting_bytes;

  // Advance the parser by one received byte; return 1 with a decoded frame
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output frame_t f);
    f = '0;
    decode_byte = 1'b0;
    if (b == cur_start) begin
      pr_phase = GET_CMD;
      return 1'b0;
    end
    case (pr_phase)
      GET_CMD: begin
        pr_cmd   = b;
        pr_xor   = b;
        pr_phase = GET_LEN;
      end
      GET_LEN: begin
        if (b > MAX_LEN) begin
          pr_phase = HUNT;
        end else begin
          pr_len   = b[LEN_W-1:0];
          pr_xor   = pr_xor ^ b;
          pr_count = 0;
          pr_phase = GET_BODY;
        end
      end
      GET_BODY: begin
        pr_body[pr_count] = b;
        if (pr_count < pr_len) pr_xor = pr_xor ^ b;
        pr_count = pr_count + 1;
        if (pr_count >= pr_len + 2) pr_phase = GET_END;
      end
      GET_END: begin
        if (b == cur_end && pr_body[pr_len] == pr_xor) begin
          f.command   = pr_cmd;
          f.length    = pr_len;
          f.first     = (pr_len >= 1) ? pr_body[0] : '0;
          f.second    = (pr_len >= 2) ? pr_body[1] : '0;
          decode_byte = 1'b1;
        end
        pr_phase = HUNT;
      end
      default: pr_phase = HUNT;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH %0d: %s", fail_count, msg);
  endfunction

  // Track every handshake: predict on received words, check decoded frames
  always @(posedge clk_i) begin
    frame_t calc;
    frame_t want;
    logic   made;
    if (!rst_ni) begin
      pr_phase    = HUNT;
      pr_cmd      = '0;
      pr_len      = '0;
      pr_count    = 0;
      pr_xor      = '0;
      cur_start   = fdx_pkg::START_BYTE_RST;
      cur_end     = fdx_pkg::END_BYTE_RST;
      idle_cycles <= 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          fdx_pkg::CFG_START_BYTE: cur_start = cfg_bus.data;
          fdx_pkg::CFG_END_BYTE:   cur_end   = cfg_bus.data;
          default: ;
        endcase
      end
      if (rx_bus.valid && rx_bus.ready) begin
        made = decode_byte(rx_bus.rx_byte, calc);
        bytes_seen++;
        if (typed_on) frames_due.push_back(typed_frame);
        else if (made) frames_due.push_back(calc);
      end
      if (frame_bus.valid && frame_bus.ready) begin
        frames_seen++;
        if (frames_due.size() == 0) begin
          note_failure($sformatf("unexpected frame cmd %h len %0d bytes %h %h",
                                 frame_bus.frame_command, frame_bus.frame_length,
                                 frame_bus.payload_first, frame_bus.payload_second));
        end else begin
          want = frames_due.pop_front();
          if (frame_bus.frame_command !== want.command ||
              frame_bus.frame_length !== want.length ||
              frame_bus.payload_first !== want.first ||
              frame_bus.payload_second !== want.second) begin
            note_failure($sformatf(
              "expected cmd %h len %0d bytes %h %h, got cmd %h len %0d bytes %h %h",
              want.command, want.length, want.first, want.second,
              frame_bus.frame_command, frame_bus.frame_length,
              frame_bus.payload_first, frame_bus.payload_second));
          end
        end
      end
      if ((rx_bus.valid && rx_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
          (frame_bus.valid && frame_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Stall the frame output on a rotating pattern, reloaded at random when pat_age wraps
  logic [15:0] stall_pat = '1;
  logic [5:0]  pat_age   = '0;
  always @(posedge clk_i) begin
    pat_age <= pat_age + 1'b1;
    if (pat_age == 6'd63) begin
      case ($urandom_range(0, 2))
        0:       stall_pat <= '1;
        1:       stall_pat <= 16'($urandom) | 16'h1;
        default: stall_pat <= 16'($urandom & $urandom) | 16'h1;
      endcase
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    frame_bus.ready <= stall_pat[0];
  end

  // End the run when nothing moves for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Present one word and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed, input frame_t f);
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    typed_on       <= typed;
    typed_frame    <= f;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every expected frame is out, then drain
  task automatic settle();
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] free_byte();
    logic [BYTE_W-1:0] r;
    do r = BYTE_W'($urandom); while (r == ph_start);
    return r;
  endfunction

  // Queue one frame, a corrupted frame or a few noise bytes
  task automatic add_frame();
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] p;
    int                kind;
    int                len;
    int                cut;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 4)) tx_q.push_back(BYTE_W'($urandom));
      return;
    end
    len = $urandom_range(0, MAX_LEN);
    cmd = free_byte();
    chk = cmd ^ BYTE_W'(len);
    body.push_back(ph_start);
    body.push_back(cmd);
    body.push_back(BYTE_W'(len));
    for (int i = 0; i < len; i++) begin
      p = free_byte();
      chk = chk ^ p;
      body.push_back(p);
    end
    body.push_back(chk);
    body.push_back(free_byte());
    body.push_back(ph_end);
    // Break roughly a quarter of the frames
    if (kind >= 75) begin
      case ($urandom_range(0, 4))
        0: body[3 + len] = body[3 + len] ^ BYTE_W'(1 << $urandom_range(0, 7));
        1: body[body.size() - 1] = ph_end + BYTE_W'($urandom_range(1, 255));
        2: body[2] = BYTE_W'($urandom_range(MAX_LEN + 1, 255));
        3: begin
          cut = $urandom_range(1, body.size() - 2);
          repeat (cut) void'(body.pop_back());
        end
        default: body.insert($urandom_range(1, body.size() - 1), ph_start);
      endcase
    end
    setting_bytes += body.size();
    foreach (body[i]) tx_q.push_back(body[i]);
  endtask

  // Send queued words in bursts with optional random gaps
  task automatic play_bytes(input bit gaps);
    int burst;
    while (tx_q.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && tx_q.size() != 0) begin
        send_byte(tx_q.pop_front(), 1'b0, NO_FRAME);
        burst--;
      end
      if (gaps && $urandom_range(0, 3) != 0) begin
        rx_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rx_bus.valid    = 1'b0;
    rx_bus.rx_byte  = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    frame_bus.ready = 1'b0;
    typed_on        = 1'b0;
    typed_frame     = '0;
    fail_count      = 0;
    bytes_seen      = 0;
    frames_seen     = 0;
    idle_cycles     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under reset register values
    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].frame);
    settle();

    // Random frames under each start/end setting
    for (int s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0: begin ph_start = 8'h00; ph_end = 8'hFF; end
        1: begin ph_start = 8'hFF; ph_end = 8'h00; end
        2: begin ph_start = 8'h5A; ph_end = 8'h5A; end
        5: begin ph_start = fdx_pkg::START_BYTE_RST; ph_end = fdx_pkg::END_BYTE_RST; end
        default: begin
          ph_start = BYTE_W'($urandom);
          ph_end   = BYTE_W'($urandom);
        end
      endcase
      write_reg(fdx_pkg::CFG_START_BYTE, ph_start);
      write_reg(fdx_pkg::CFG_END_BYTE, ph_end);
      write_reg(CFG_IDX_SPARE, BYTE_W'($urandom));
      setting_bytes = 0;
      while (setting_bytes < SETTING_BYTES) add_frame();
      play_bytes(s != 3);
      settle();
    end

    if (frames_due.size() != 0)
      note_failure($sformatf("%0d expected frames never arrived", frames_due.size()));
    $display("Covered %0d received bytes under %0d start/end settings, %0d frames decoded.",
             bytes_seen, N_SETTINGS + 1, frames_seen);
    $display("Failures: %0d", fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
